### rtl/icm_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt cause/mask package
// Transaction types, operation codes, register offsets and fixed constants
// shared by the interrupt cause/mask interface modules.
// ----------------------------------------------------------------------------
package icm_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned OFFSET_W = 8;
   localparam int unsigned INDEX_W  = 5;

   localparam logic [OP_W-1:0] OP_BUS_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_BUS_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_SOURCE    = 3'd2;
   localparam logic [OP_W-1:0] OP_EXTRA     = 3'd3;
   localparam logic [OP_W-1:0] OP_EVALUATE  = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_WPTR  = 3'd5;

   localparam logic [OFFSET_W-1:0] OFF_CAUSE    = 8'h00;
   localparam logic [OFFSET_W-1:0] OFF_MASK     = 8'h04;
   localparam logic [OFFSET_W-1:0] OFF_BASE     = 8'h0C;
   localparam logic [OFFSET_W-1:0] OFF_END      = 8'h10;
   localparam logic [OFFSET_W-1:0] OFF_WPTR     = 8'h14;
   localparam logic [OFFSET_W-1:0] OFF_RESET    = 8'h24;
   localparam logic [OFFSET_W-1:0] OFF_REVISION = 8'h2C;

   localparam logic [DATA_W-1:0] REVISION_WORD = 32'h0000_0011;
   localparam logic [DATA_W-1:0] ALIGN_MASK    = ~32'd31;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [OFFSET_W-1:0] offset;
      logic [DATA_W-1:0]   write_data;
      logic [INDEX_W-1:0]  source_index;
      logic                source_level;
      logic                cpu_int_enable;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              unmapped;
      logic              interrupt_line;
      logic              exit_request;
      logic [DATA_W-1:0] raise_total;
   } rsp_type;

endpackage

### rtl/icm_core.sv
// ----------------------------------------------------------------------------
// Interrupt cause/mask register core
// Holds the cause, mask, ring base, end and pointer, reset word and raise counter registers
// and computes the result of one transaction in a single pass.
// ----------------------------------------------------------------------------
module icm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  icm_pkg::req_type item,
   input  logic             exit_disable,
   output icm_pkg::rsp_type result
);

   logic [icm_pkg::DATA_W-1:0] cause_ff, cause_in;
   logic [icm_pkg::DATA_W-1:0] mask_ff, mask_in;
   logic [icm_pkg::DATA_W-1:0] base_ff, base_in;
   logic [icm_pkg::DATA_W-1:0] end_ff, end_in;
   logic [icm_pkg::DATA_W-1:0] wptr_ff, wptr_in;
   logic [icm_pkg::DATA_W-1:0] reset_word_ff, reset_word_in;
   logic [icm_pkg::DATA_W-1:0] raise_ff, raise_in;

   logic [icm_pkg::DATA_W-1:0] source_bit;
   logic                       evaluate;
   logic                       line;

   assign source_bit = icm_pkg::DATA_W'(1) << item.source_index;

   always_comb begin
      cause_in      = cause_ff;
      mask_in       = mask_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      wptr_in       = wptr_ff;
      reset_word_in = reset_word_ff;
      raise_in      = raise_ff;
      evaluate      = 1'b0;
      result.read_data = '0;
      result.unmapped  = 1'b0;
      case (item.operation)
         icm_pkg::OP_BUS_READ: begin
            unique case (item.offset)
               icm_pkg::OFF_CAUSE:    result.read_data = cause_ff;
               icm_pkg::OFF_MASK:     result.read_data = mask_ff;
               icm_pkg::OFF_BASE:     result.read_data = base_ff;
               icm_pkg::OFF_END:      result.read_data = end_ff;
               icm_pkg::OFF_WPTR:     result.read_data = wptr_ff;
               icm_pkg::OFF_RESET:    result.read_data = reset_word_ff;
               icm_pkg::OFF_REVISION: result.read_data = icm_pkg::REVISION_WORD;
               default:               result.unmapped  = 1'b1;
            endcase
         end
         icm_pkg::OP_BUS_WRITE: begin
            unique case (item.offset)
               icm_pkg::OFF_CAUSE: begin
                  cause_in = cause_ff & ~item.write_data;
                  evaluate = 1'b1;
               end
               icm_pkg::OFF_MASK: begin
                  mask_in  = item.write_data;
                  evaluate = 1'b1;
               end
               icm_pkg::OFF_BASE:  base_in       = item.write_data & icm_pkg::ALIGN_MASK;
               icm_pkg::OFF_END:   end_in        = item.write_data & icm_pkg::ALIGN_MASK;
               icm_pkg::OFF_WPTR:  wptr_in       = item.write_data & icm_pkg::ALIGN_MASK;
               icm_pkg::OFF_RESET: reset_word_in = item.write_data;
               default:            result.unmapped = 1'b1;
            endcase
         end
         icm_pkg::OP_SOURCE: begin
            if (item.source_level) begin
               if ((cause_ff & source_bit) == '0) begin
                  raise_in = raise_ff + icm_pkg::DATA_W'(1);
               end
               cause_in = cause_ff | source_bit;
            end else begin
               cause_in = cause_ff & ~source_bit;
            end
            evaluate = 1'b1;
         end
         icm_pkg::OP_EXTRA: begin
            raise_in = raise_ff + icm_pkg::DATA_W'(1);
         end
         icm_pkg::OP_EVALUATE: begin
            evaluate = 1'b1;
         end
         icm_pkg::OP_SET_WPTR: begin
            wptr_in = item.write_data;
         end
         default: begin
         end
      endcase
      line                  = (cause_in & mask_in) != '0;
      result.interrupt_line = line;
      result.exit_request   = evaluate && line && item.cpu_int_enable && !exit_disable;
      result.raise_total    = raise_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cause_ff      <= '0;
         mask_ff       <= '0;
         base_ff       <= '0;
         end_ff        <= '0;
         wptr_ff       <= '0;
         reset_word_ff <= '0;
         raise_ff      <= '0;
      end else if (fire) begin
         cause_ff      <= cause_in;
         mask_ff       <= mask_in;
         base_ff       <= base_in;
         end_ff        <= end_in;
         wptr_ff       <= wptr_in;
         reset_word_ff <= reset_word_in;
         raise_ff      <= raise_in;
      end
   end

   a_exit_needs_line: assert property (@(posedge clock) disable iff (reset)
      fire && result.exit_request |-> result.interrupt_line && !exit_disable)
      else $error("exit request without a pending unmasked interrupt");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(cause_ff) && $stable(mask_ff) && $stable(raise_ff))
      else $error("register state changed without a transaction");

   a_counter_step: assert property (@(posedge clock) disable iff (reset)
      fire |=> (raise_ff == $past(raise_ff)) || (raise_ff == $past(raise_ff) + 32'd1))
      else $error("raise counter moved by more than one");

endmodule

### rtl/interrupt_cause_mask_interface_top.sv
// The request register feeds the core, whose result enters the response register when free.
// Throughput: one transaction per cycle unless rsp_ready stalls; the core sets this rate.
// The request register lets a new request enter while a response waits.
// Synchronous active-high reset clears the valid flags, core registers and exit-disable bit.
// ----------------------------------------------------------------------------
// Interrupt cause/mask interface top level
// Request register, single-pass register core and response register, plus
// the exit-disable control register.
// ----------------------------------------------------------------------------
module interrupt_cause_mask_interface_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  icm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output icm_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_write_data
);

   logic             req_valid_ff, req_valid_in;
   icm_pkg::req_type req_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   icm_pkg::rsp_type rsp_item_ff;
   logic             exit_disable_ff;
   logic             out_free;
   logic             fire;
   logic             req_take;
   icm_pkg::rsp_type core_result;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign fire         = req_valid_ff && out_free;
   assign req_ready    = !req_valid_ff || fire;
   assign req_take     = req_valid && req_ready;
   assign req_valid_in = req_take || (req_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   icm_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (req_item_ff),
      .exit_disable (exit_disable_ff),
      .result       (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         exit_disable_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            exit_disable_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_payload;
      end
      if (fire) begin
         rsp_item_ff <= core_result;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !fire)
      else $error("response overwritten while stalled");

   a_pending_request: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !fire |=> req_valid_ff && $stable(req_item_ff))
      else $error("pending request lost");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed transaction produced no response");

endmodule
